// ===== src/bswr_pkg.sv =====
// shared types and constants for the bounded stack with remove
package bswr_pkg;

  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_W   = 8;
  localparam int DEPTH_DEF = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic load;
    logic search;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== src/bswr_cell.sv =====
// one stack slot: word register, match flag and downward shift
module bswr_cell #(
  parameter int DEPTH = bswr_pkg::DEPTH_DEF,
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  bswr_pkg::cell_ctrl_t              ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  logic signed [bswr_pkg::DATA_W-1:0] value_i,
  input  logic signed [bswr_pkg::DATA_W-1:0] up_data_i,
  input  logic                              hit_above_i,
  output logic signed [bswr_pkg::DATA_W-1:0] data_o,
  output logic                              hit_above_o
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

  logic signed [bswr_pkg::DATA_W-1:0] data_r;
  logic                               match_r;

  always_ff @(posedge clk) begin
    if (ctrl_i.load && (count_i == MY_INDEX)) begin
      data_r <= value_i;
    end else if (ctrl_i.shift && !hit_above_i) begin
      // at or above the topmost match: take the word from the slot above
      data_r <= up_data_i;
    end
    if (ctrl_i.search) begin
      match_r <= (data_r == value_i) && (MY_INDEX < count_i);
    end
  end

  assign data_o      = data_r;
  assign hit_above_o = hit_above_i | match_r;

endmodule

// ===== src/bounded_stack_with_remove_core.sv =====
// top level: bounded lifo stack with remove-by-value built as a chain of cells
// push, pop and clear give their result transaction in the cycle after acceptance
// remove loads the match flags, then gives its result from ST_REMOVE when the output is free
// throughput: one push, pop or clear per cycle unless the output stalls
// a remove stalls input in ST_REMOVE, which resolves the topmost-match or-chain of all cells
// reset: synchronous, active low; empties the stack and output register, slot words keep data
module bounded_stack_with_remove_core #(
  parameter int DEPTH = bswr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bswr_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [bswr_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bswr_pkg::STATUS_W-1:0]      out_status,
  output logic [bswr_pkg::DEPTH_W-1:0]       out_depth
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_REMOVE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bswr_pkg::status_t      out_status_r, out_status_nxt;
  logic [CW-1:0]          res_count_r;

  logic                   accept;
  logic                   out_free;
  logic                   finish;
  logic                   found;
  bswr_pkg::cell_ctrl_t   ctrl;

  // chain wiring: words flow down, the hit flag ripples down from the top
  logic signed [bswr_pkg::DATA_W-1:0] data_w [DEPTH];
  logic [DEPTH:0]                     hit_w;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // remove completes once the match flags are in and the result can be stored
  assign finish   = (state_r == ST_REMOVE) && out_free;
  assign found    = hit_w[0];

  assign ctrl.load   = accept && (in_kind == bswr_pkg::KIND_PUSH) && (count_r != FULL_COUNT);
  assign ctrl.search = accept && (in_kind == bswr_pkg::KIND_REMOVE);
  assign ctrl.shift  = finish && found;

  assign hit_w[DEPTH] = 1'b0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic signed [bswr_pkg::DATA_W-1:0] up_data;
    if (j == DEPTH-1) begin : g_top
      assign up_data = data_w[j];
    end else begin : g_mid
      assign up_data = data_w[j+1];
    end

    bswr_cell #(
      .DEPTH (DEPTH),
      .INDEX (j)
    ) u_cell (
      .clk         (clk),
      .ctrl_i      (ctrl),
      .count_i     (count_r),
      .value_i     (in_value),
      .up_data_i   (up_data),
      .hit_above_i (hit_w[j+1]),
      .data_o      (data_w[j]),
      .hit_above_o (hit_w[j])
    );
  end

  // next state, new fill count and the result of the transaction
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (accept) begin
      out_status_nxt = bswr_pkg::STATUS_OK;
      unique case (in_kind)
        bswr_pkg::KIND_PUSH: begin
          out_valid_nxt = 1'b1;
          if (count_r == FULL_COUNT) begin
            out_status_nxt = bswr_pkg::STATUS_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        bswr_pkg::KIND_POP: begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_status_nxt = bswr_pkg::STATUS_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        bswr_pkg::KIND_REMOVE: begin
          // match flags load at this edge, result follows from ST_REMOVE once the output register is free
          state_nxt = ST_REMOVE;
        end
        bswr_pkg::KIND_CLEAR: begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end else if (finish) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      if (found) begin
        out_status_nxt = bswr_pkg::STATUS_OK;
        count_nxt      = count_r - 1'b1;
      end else begin
        out_status_nxt = bswr_pkg::STATUS_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      if (out_valid_nxt && !(out_valid_r && out_stall)) begin
        res_count_r <= count_nxt;
      end
    end
  end

  // depth field carries the low bits of the count
  logic [CW+bswr_pkg::DEPTH_W-1:0] depth_ext;
  assign depth_ext  = {{bswr_pkg::DEPTH_W{1'b0}}, res_count_r};
  assign out_depth  = depth_ext[bswr_pkg::DEPTH_W-1:0];
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // fill count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("fill count above capacity");

  // no new transaction while a remove is still resolving
  a_remove_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REMOVE) |-> in_stall)
    else $error("input accepted during remove");

  // accepted remove always moves to the resolve cycle
  a_remove_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == bswr_pkg::KIND_REMOVE)) |=> (state_r == ST_REMOVE))
    else $error("remove did not enter resolve cycle");

  // a successful remove drops exactly one entry
  a_remove_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |=> (count_r == $past(count_r) - 1'b1))
    else $error("remove did not shrink stack by one");

  // a result is only produced from an idle accept or a finished remove
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !accept && !finish) |=> !out_valid_r)
    else $error("result appeared without a transaction");

endmodule

// ===== tb/bswr_checker.sv =====
// checker for the bounded stack: predicts each result and compares it on the output channel
`timescale 1ns / 100ps

module bswr_checker #(
  parameter int DEPTH = bswr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [bswr_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [bswr_pkg::DATA_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [bswr_pkg::STATUS_W-1:0]      out_status,
  input  logic [bswr_pkg::DEPTH_W-1:0]       out_depth,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 ops_seen,
  output int                                 results_checked,
  output int                                 full_hits,
  output int                                 empty_hits,
  output int                                 miss_hits,
  output int                                 deepest
);

  typedef struct {
    bswr_pkg::status_t               status;
    logic [bswr_pkg::DEPTH_W-1:0]    depth;
  } stack_reply_t;

  logic signed [bswr_pkg::DATA_W-1:0] stack_words [DEPTH];
  int                                 stack_fill;
  stack_reply_t                       reply_q [$];
  int n_fail, n_ops, n_checked, n_full, n_empty, n_miss, n_deep;

  function automatic stack_reply_t apply_stack_op(bswr_pkg::kind_t k,
                                                  logic signed [bswr_pkg::DATA_W-1:0] v);
    stack_reply_t r;
    int           hit;
    r.status = bswr_pkg::STATUS_OK;
    hit = -1;
    case (k)
      bswr_pkg::KIND_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.status = bswr_pkg::STATUS_FULL;
        end else begin
          stack_words[stack_fill] = v;
          stack_fill++;
        end
      end
      bswr_pkg::KIND_POP: begin
        if (stack_fill == 0) r.status = bswr_pkg::STATUS_EMPTY;
        else stack_fill--;
      end
      bswr_pkg::KIND_REMOVE: begin
        for (int i = stack_fill - 1; i >= 0; i--)
          if (hit < 0 && stack_words[i] == v) hit = i;
        if (hit < 0) begin
          r.status = bswr_pkg::STATUS_NOT_FOUND;
        end else begin
          for (int j = hit; j < stack_fill - 1; j++) stack_words[j] = stack_words[j+1];
          stack_fill--;
        end
      end
      default: stack_fill = 0;
    endcase
    r.depth = stack_fill[bswr_pkg::DEPTH_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    if (!rst_n) begin
      stack_fill = 0;
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with nothing expected, status %0d depth %0d",
                   $time, out_status, out_depth);
        end else begin
          want = reply_q.pop_front();
          n_checked++;
          if (out_status !== want.status) begin
            n_fail++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_status);
          end
          if (out_depth !== want.depth) begin
            n_fail++;
            $display("%0t: depth mismatch, expected %0d actual %0d",
                     $time, want.depth, out_depth);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_stack_op(bswr_pkg::kind_t'(in_kind), in_value);
        reply_q.push_back(want);
        n_ops++;
        if (want.status == bswr_pkg::STATUS_FULL) n_full++;
        if (want.status == bswr_pkg::STATUS_EMPTY) n_empty++;
        if (want.status == bswr_pkg::STATUS_NOT_FOUND) n_miss++;
        if (stack_fill > n_deep) n_deep = stack_fill;
      end
    end
    fail_count      <= n_fail;
    pending         <= reply_q.size();
    ops_seen        <= n_ops;
    results_checked <= n_checked;
    full_hits       <= n_full;
    empty_hits      <= n_empty;
    miss_hits       <= n_miss;
    deepest         <= n_deep;
  end

  initial begin
    n_fail = 0; n_ops = 0; n_checked = 0;
    n_full = 0; n_empty = 0; n_miss = 0; n_deep = 0;
    stack_fill = 0;
  end

endmodule

// ===== tb/testbench.sv =====
// top of the bounded stack testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH      = bswr_pkg::DEPTH_DEF;
  localparam int N_RANDOM   = 1600;
  localparam int IDLE_LIMIT = 4000;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [bswr_pkg::KIND_W-1:0]        in_kind;
  logic signed [bswr_pkg::DATA_W-1:0] in_value;
  logic                               out_valid;
  logic                               out_stall;
  logic [bswr_pkg::STATUS_W-1:0]      out_status;
  logic [bswr_pkg::DEPTH_W-1:0]       out_depth;

  int fail_count, pending, ops_seen, results_checked;
  int full_hits, empty_hits, miss_hits, deepest;

  // sender burst, watchdog and receiver stall bookkeeping
  int burst_left;
  int idle_cycles;
  int stall_tick;
  int stall_mode;

  always #2 clk = ~clk;

  bounded_stack_with_remove_core #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_depth  (out_depth)
  );

  bswr_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_depth       (out_depth),
    .fail_count      (fail_count),
    .pending         (pending),
    .ops_seen        (ops_seen),
    .results_checked (results_checked),
    .full_hits       (full_hits),
    .empty_hits      (empty_hits),
    .miss_hits       (miss_hits),
    .deepest         (deepest)
  );

  // receiver stall pattern: modes drawn at random, from never stalling to mostly stalling
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_tick <= 0;
      stall_mode <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 4);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        4:       out_stall <= stall_tick[0];
        default: out_stall <= ($urandom_range(0, 3) < stall_mode);
      endcase
    end
  end

  // watchdog: any cycle with no transaction on either channel counts towards the limit
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one operation, with a random gap at the end of each burst; waits for acceptance
  task automatic send_op(input bswr_pkg::kind_t k,
                         input logic signed [bswr_pkg::DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= k;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender holds off until every outstanding result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [bswr_pkg::DATA_W-1:0] pool [6];
    int                                 mode, phase_len, sent, pick, first_phase;
    bswr_pkg::kind_t                    k;
    logic signed [bswr_pkg::DATA_W-1:0] v;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_kind    <= bswr_pkg::KIND_PUSH;
    in_value   <= '0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-stack corners first
    send_op(bswr_pkg::KIND_POP, 0);
    send_op(bswr_pkg::KIND_REMOVE, 0);
    send_op(bswr_pkg::KIND_CLEAR, 32'h7FFF_FFFF);
    // extremes of the word
    send_op(bswr_pkg::KIND_PUSH, 32'sh8000_0000);
    send_op(bswr_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
    send_op(bswr_pkg::KIND_PUSH, 0);
    send_op(bswr_pkg::KIND_PUSH, -1);
    // duplicates: only the copy nearest the top goes, so 7 ends up popped
    send_op(bswr_pkg::KIND_PUSH, 5);
    send_op(bswr_pkg::KIND_PUSH, 7);
    send_op(bswr_pkg::KIND_PUSH, 5);
    send_op(bswr_pkg::KIND_REMOVE, 5);
    send_op(bswr_pkg::KIND_POP, 0);
    send_op(bswr_pkg::KIND_REMOVE, 7);
    // no match on a non-empty stack, then a removal from the bottom
    send_op(bswr_pkg::KIND_REMOVE, 32'h1234_5678);
    send_op(bswr_pkg::KIND_REMOVE, 32'sh8000_0000);
    send_op(bswr_pkg::KIND_PUSH, 32'h5555_5555);
    send_op(bswr_pkg::KIND_PUSH, 32'shAAAA_AAAA);
    send_op(bswr_pkg::KIND_REMOVE, -1);
    send_op(bswr_pkg::KIND_POP, 0);
    send_op(bswr_pkg::KIND_CLEAR, 0);
    send_op(bswr_pkg::KIND_POP, 0);

    drain_results();

    // random phases: fill, drain or mixed, with values drawn mostly from a small pool
    // so that removes find matches; the first phase is a long fill to hit the full case
    sent = 0;
    first_phase = 1;
    while (sent < N_RANDOM) begin
      foreach (pool[i]) pool[i] = $urandom;
      if (first_phase) begin
        mode = 0;
        phase_len = DEPTH + 60;
      end else begin
        mode = $urandom_range(0, 2);
        phase_len = $urandom_range(20, 220);
      end
      for (int n = 0; n < phase_len && sent < N_RANDOM; n++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0:       k = (pick < (first_phase ? 95 : 85)) ? bswr_pkg::KIND_PUSH :
                       (pick < 92) ? bswr_pkg::KIND_POP :
                       (pick < 98) ? bswr_pkg::KIND_REMOVE : bswr_pkg::KIND_CLEAR;
          1:       k = (pick < 15) ? bswr_pkg::KIND_PUSH :
                       (pick < 60) ? bswr_pkg::KIND_POP :
                       (pick < 98) ? bswr_pkg::KIND_REMOVE : bswr_pkg::KIND_CLEAR;
          default: k = (pick < 45) ? bswr_pkg::KIND_PUSH :
                       (pick < 70) ? bswr_pkg::KIND_POP :
                       (pick < 98) ? bswr_pkg::KIND_REMOVE : bswr_pkg::KIND_CLEAR;
        endcase
        if ($urandom_range(0, 99) < 85) v = pool[$urandom_range(0, 5)];
        else v = $urandom;
        send_op(k, v);
        sent++;
      end
      first_phase = 0;
      // occasionally let the block run dry between phases
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (6) @(posedge clk);

    $display("ran %0d stack operations, %0d results compared, deepest stack %0d of %0d",
             ops_seen, results_checked, deepest, DEPTH);
    $display("full on push %0d, empty on pop %0d, not found on remove %0d",
             full_hits, empty_hits, miss_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bswr_pkg.sv
src/bswr_cell.sv
src/bounded_stack_with_remove_core.sv
tb/bswr_checker.sv
tb/testbench.sv
